@@ hw/rtl/ptc_pkg.sv @@
`default_nettype none
package ptc_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned DivBits = 32;

  localparam logic [31:0] PressBase = 32'd1048576;
  localparam logic [31:0] TempOfs   = 32'd64000;
  localparam logic [31:0] PressMul  = 32'd3125;
  localparam logic [31:0] HalfRange = 32'h8000_0000;
  localparam logic [31:0] P1Ofs     = 32'd32768;
  localparam logic [31:0] RoundOfs  = 32'd128;

  localparam logic [1:0] RegTemp    = 2'd0;
  localparam logic [1:0] RegPressLo = 2'd1;
  localparam logic [1:0] RegPressMd = 2'd2;
  localparam logic [1:0] RegPressHi = 2'd3;

  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } coef_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic [31:0] divisor;
    logic [31:0] dividend;
    logic        big;
    logic        invalid;
  } req_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic        big;
    logic        invalid;
  } side_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] sar(input logic [31:0] x, input logic [4:0] n);
    sar = $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ptc_front.sv @@
`default_nettype none
module ptc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [19:0]   raw_t,
  input  wire logic [19:0]   raw_p,
  input  wire ptc_pkg::coef_t coef,
  output logic               out_valid,
  output ptc_pkg::req_t      out_req
);
  import ptc_pkg::*;

  logic [9:0]  v_r;
  logic [31:0] adcp_r [0:7];
  logic [31:0] x1_r, d_r, m1_r, dd_r, a_r, m3_r, fine_r [4:9], tc_r [5:9];
  logic [31:0] pa_r, q_r, sq_r, ap5_r, p2a_r, ap5b_r, p2ab_r, b1_r, c1_r;
  logic [31:0] b_r, a2_r, a3m_r, nb_r, div_r, num_r, tc10_r, fine10_r;
  logic [31:0] fine_tmp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[8:0], in_valid};
    end
  end

  assign fine_tmp = fine_r[4];

  always_ff @(posedge clk) begin
    adcp_r[0] <= {12'd0, raw_p};
    for (int i = 1; i < 8; i++) adcp_r[i] <= adcp_r[i-1];
    x1_r  <= {15'd0, raw_t[19:3]} - {coef.t1[30:0], 1'b0};
    d_r   <= {16'd0, raw_t[19:4]} - coef.t1;
    m1_r  <= x1_r * coef.t2;
    dd_r  <= d_r * d_r;
    a_r   <= sar(m1_r, 5'd11);
    m3_r  <= sar(dd_r, 5'd12) * coef.t3;
    fine_r[4] <= a_r + sar(m3_r, 5'd14);
    tc_r[5] <= sar({fine_tmp[29:0], 2'b00} + fine_tmp + RoundOfs, 5'd8);
    fine_r[5] <= fine_tmp;
    pa_r  <= sar(fine_tmp, 5'd1) - TempOfs;
    q_r   <= sar(sar(fine_tmp, 5'd1) - TempOfs, 5'd2);
    sq_r  <= q_r * q_r;
    ap5_r <= pa_r * coef.p5;
    p2a_r <= coef.p2 * pa_r;
    b1_r  <= sar(sq_r, 5'd11) * coef.p6;
    c1_r  <= coef.p3 * sar(sq_r, 5'd13);
    ap5b_r <= ap5_r;
    p2ab_r <= p2a_r;
    b_r   <= sar(b1_r + {ap5b_r[30:0], 1'b0}, 5'd2) + {coef.p4[15:0], 16'd0};
    a2_r  <= sar(sar(c1_r, 5'd3) + sar(p2ab_r, 5'd1), 5'd18);
    a3m_r <= (P1Ofs + a2_r) * coef.p1;
    nb_r  <= (PressBase - adcp_r[7]) - sar(b_r, 5'd12);
    div_r <= sar(a3m_r, 5'd15);
    num_r <= nb_r * PressMul;
    for (int i = 6; i < 10; i++) begin
      fine_r[i] <= fine_r[i-1];
      tc_r[i]   <= tc_r[i-1];
    end
    fine10_r <= fine_r[9];
    tc10_r   <= tc_r[9];
  end

  assign out_valid        = v_r[9];
  assign out_req.tc       = tc10_r;
  assign out_req.fine     = fine10_r;
  assign out_req.divisor  = div_r;
  assign out_req.big      = (num_r >= HalfRange);
  assign out_req.dividend = (num_r >= HalfRange) ? num_r : {num_r[30:0], 1'b0};
  assign out_req.invalid  = (div_r == 32'd0);

endmodule
`default_nettype wire

@@ hw/rtl/ptc_queue.sv @@
`default_nettype none
module ptc_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire ptc_pkg::req_t    push_req,
  input  wire logic             pop,
  output ptc_pkg::req_t         pop_req,
  output ptc_pkg::q_status_t    status
);
  import ptc_pkg::*;

  req_t          mem_r [0:QDepth-1];
  logic [QAw-1:0] wp_r, rp_r;
  logic [QAw:0]   cnt_r, cnt_nxt;

  assign cnt_nxt = cnt_r + (QAw+1)'(push) - (QAw+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_req;
  end

  assign pop_req      = mem_r[rp_r];
  assign status.full  = (cnt_r == (QAw+1)'(QDepth));
  assign status.empty = (cnt_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("count slip");

endmodule
`default_nettype wire

@@ hw/rtl/ptc_back.sv @@
`default_nettype none
module ptc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire ptc_pkg::req_t  in_req,
  input  wire ptc_pkg::coef_t coef,
  output logic                out_valid,
  output logic [31:0]         tc,
  output logic [31:0]         pr,
  output logic [31:0]         fine,
  output logic                invalid
);
  import ptc_pkg::*;

  logic [DivBits:0] vld_r;
  logic [31:0] rem_r [0:DivBits];
  logic [31:0] nq_r  [0:DivBits];
  logic [31:0] dv_r  [0:DivBits];
  side_t       sd_r  [0:DivBits];
  logic [2:0]  pv_r;
  side_t       ps_r [0:2];
  logic [31:0] pr1_r, pr2_r, m8_r, m8b_r, sqs_r, m9_r, quo;
  logic [31:0] tc_r, pr_r, fine_r;
  logic        inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      pv_r  <= '0;
    end else begin
      vld_r <= {vld_r[DivBits-1:0], in_valid};
      pv_r  <= {pv_r[1:0], vld_r[DivBits]};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    nq_r[0]  <= in_req.dividend;
    dv_r[0]  <= in_req.divisor;
    sd_r[0]  <= '{tc: in_req.tc, fine: in_req.fine, big: in_req.big, invalid: in_req.invalid};
  end

  for (genvar g = 0; g < DivBits; g++) begin : g_div
    logic [32:0] t;
    logic        ge;
    assign t  = {rem_r[g], nq_r[g][31]};
    assign ge = (t >= {1'b0, dv_r[g]});
    always_ff @(posedge clk) begin
      rem_r[g+1] <= ge ? 32'(t - {1'b0, dv_r[g]}) : t[31:0];
      nq_r[g+1]  <= {nq_r[g][30:0], ge};
      dv_r[g+1]  <= dv_r[g];
      sd_r[g+1]  <= sd_r[g];
    end
  end

  assign quo = sd_r[DivBits].big ? {nq_r[DivBits][30:0], 1'b0} : nq_r[DivBits];

  always_ff @(posedge clk) begin
    ps_r[0] <= sd_r[DivBits];
    pr1_r   <= quo;
    m8_r    <= {2'd0, quo[31:2]} * coef.p8;
    sqs_r   <= {3'd0, quo[31:3]} * {3'd0, quo[31:3]};
    ps_r[1] <= ps_r[0];
    pr2_r   <= pr1_r;
    m8b_r   <= m8_r;
    m9_r    <= coef.p9 * {13'd0, sqs_r[31:13]};
    tc_r    <= ps_r[1].tc;
    fine_r  <= ps_r[1].fine;
    inv_r   <= ps_r[1].invalid;
    pr_r    <= ps_r[1].invalid ? 32'd0 :
               pr2_r + sar(sar(m9_r, 5'd12) + sar(m8b_r, 5'd13) + coef.p7, 5'd4);
  end

  assign out_valid = pv_r[2];
  assign tc        = tc_r;
  assign pr        = pr_r;
  assign fine      = fine_r;
  assign invalid   = inv_r;

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && invalid) |-> (pr == 32'd0)) else $error("invalid with pressure");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DivBits] |-> ##3 out_valid) else $error("result lost");

endmodule
`default_nettype wire

@@ hw/rtl/pressure_temperature_compensation.sv @@
`default_nettype none
// A request accepted on start passes through the front pipeline, the queue and
// the divider and polynomial stages of the back end before out_valid rises.
// Throughput: one request per cycle while busy is low; every stage, including the 32-step
// restoring divider, is fully pipelined, so busy stays low in normal use.
// Reset (rst_n low, synchronous) clears all valid bits, the queue and the
// four coefficient registers; the receiver cannot stall.
module pressure_temperature_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [19:0] in_raw_temperature,
  input  wire logic [19:0] in_raw_pressure,
  output logic             out_valid,
  output logic [31:0]      out_temperature_centideg,
  output logic [31:0]      out_pressure_pascal,
  output logic [31:0]      out_fine_temperature,
  output logic             out_pressure_invalid,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import ptc_pkg::*;

  logic [47:0] reg_r [0:3];
  coef_t       coef;
  logic        acc, fv, pop;
  req_t        freq, qreq;
  q_status_t   qs;

  assign pready = 1'b1;
  assign busy   = qs.full;
  assign acc    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) reg_r[i] <= '0;
    end else if (psel && penable && pwrite) begin
      reg_r[paddr[4:3]] <= pwdata[47:0];
    end
  end

  assign prdata = {16'd0, reg_r[paddr[4:3]]};

  assign coef.t1 = {16'd0, reg_r[RegTemp][15:0]};
  assign coef.t2 = sext16(reg_r[RegTemp][31:16]);
  assign coef.t3 = sext16(reg_r[RegTemp][47:32]);
  assign coef.p1 = {16'd0, reg_r[RegPressLo][15:0]};
  assign coef.p2 = sext16(reg_r[RegPressLo][31:16]);
  assign coef.p3 = sext16(reg_r[RegPressLo][47:32]);
  assign coef.p4 = sext16(reg_r[RegPressMd][15:0]);
  assign coef.p5 = sext16(reg_r[RegPressMd][31:16]);
  assign coef.p6 = sext16(reg_r[RegPressMd][47:32]);
  assign coef.p7 = sext16(reg_r[RegPressHi][15:0]);
  assign coef.p8 = sext16(reg_r[RegPressHi][31:16]);
  assign coef.p9 = sext16(reg_r[RegPressHi][47:32]);

  ptc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(acc),
    .raw_t(in_raw_temperature), .raw_p(in_raw_pressure),
    .coef(coef), .out_valid(fv), .out_req(freq)
  );

  assign pop = !qs.empty;

  ptc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(fv), .push_req(freq),
    .pop(pop), .pop_req(qreq), .status(qs)
  );

  ptc_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(pop), .in_req(qreq), .coef(coef),
    .out_valid(out_valid), .tc(out_temperature_centideg),
    .pr(out_pressure_pascal), .fine(out_fine_temperature),
    .invalid(out_pressure_invalid)
  );

  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("queue backed up");

endmodule
`default_nettype wire
